// ----- rtl/smtp_body_dot_stuffer_top_macros.svh -----
// Assertion helpers for the dot stuffer.
`ifndef SMTP_BODY_DOT_STUFFER_TOP_MACROS_SVH
`define SMTP_BODY_DOT_STUFFER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sds_pkg.sv -----
package sds_pkg;

  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [15:0] CAPACITY_RESET = 16'd2048;

  typedef enum logic [2:0] {
    RUN_BYTE,
    RUN_DOTDOT,
    RUN_CRLF,
    RUN_CLOSE3,
    RUN_CLOSE5,
    RUN_OVF
  } run_kind_t;

  typedef struct packed {
    run_kind_t  kind;
    logic [7:0] data;
  } run_t;

  function automatic logic [2:0] run_len(input run_kind_t kind);
    logic [2:0] len;
    unique case (kind)
      RUN_BYTE:   len = 3'd1;
      RUN_DOTDOT: len = 3'd2;
      RUN_CRLF:   len = 3'd2;
      RUN_CLOSE3: len = 3'd3;
      RUN_CLOSE5: len = 3'd5;
      RUN_OVF:    len = 3'd1;
      default:    len = 3'd1;
    endcase
    return len;
  endfunction

  // Byte at position pos of a run; CLOSE5 is CR LF . CR LF, CLOSE3 its tail.
  function automatic logic [7:0] run_byte(input run_t run, input logic [2:0] pos);
    logic [7:0] b;
    logic [2:0] p;
    p = (run.kind == RUN_CLOSE3) ? pos + 3'd2 : pos;
    b = 8'h00;
    unique case (run.kind)
      RUN_BYTE:   b = run.data;
      RUN_DOTDOT: b = CH_DOT;
      RUN_CRLF:   b = (pos == 3'd0) ? CH_CR : CH_LF;
      RUN_CLOSE3, RUN_CLOSE5: begin
        unique case (p)
          3'd0:    b = CH_CR;
          3'd1:    b = CH_LF;
          3'd2:    b = CH_DOT;
          3'd3:    b = CH_CR;
          default: b = CH_LF;
        endcase
      end
      RUN_OVF:    b = 8'h00;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/sds_if.sv -----
interface sds_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  data_byte;
  logic [15:0] header_length;

  modport source (output valid, action, data_byte, header_length, input ready);
  modport sink (input valid, action, data_byte, header_length, output ready);
endinterface

interface sds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       overflow;

  modport source (output valid, out_byte, last, overflow, input ready);
  modport sink (input valid, out_byte, last, overflow, output ready);
endinterface

interface sds_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] message_capacity;

  modport source (output valid, message_capacity, input ready);
  modport sink (input valid, message_capacity, output ready);
endinterface

// ----- rtl/sds_front.sv -----
module sds_front
  import sds_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  sds_in_if.sink  in_ch,
  sds_cfg_if.sink cfg_ch,
  output logic  push_valid,
  input  logic  push_ready,
  output run_t  push_run
);

  logic [15:0] capacity_r, capacity_nxt;
  logic [15:0] used_r, used_nxt;
  logic        line_start_r, line_start_nxt;
  logic        failed_r, failed_nxt;

  logic        accept;
  run_kind_t   kind;
  logic        has_run;
  logic        fits;
  logic [16:0] sum;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = push_ready;
  assign accept       = in_ch.valid && push_ready;

  // Classify the item into the run it produces.
  always_comb begin
    kind    = RUN_BYTE;
    has_run = 1'b0;
    unique case (in_ch.action)
      ACT_BYTE: begin
        if (!failed_r && in_ch.data_byte != CH_CR) begin
          has_run = 1'b1;
          if (in_ch.data_byte == CH_LF) begin
            kind = RUN_CRLF;
          end else if (line_start_r && in_ch.data_byte == CH_DOT) begin
            kind = RUN_DOTDOT;
          end else begin
            kind = RUN_BYTE;
          end
        end
      end
      ACT_END: begin
        has_run = !failed_r;
        kind    = line_start_r ? RUN_CLOSE3 : RUN_CLOSE5;
      end
      ACT_START, ACT_NONE: has_run = 1'b0;
      default: has_run = 1'b0;
    endcase
  end

  assign sum  = {1'b0, used_r} + {14'd0, run_len(kind)};
  assign fits = sum <= {1'b0, capacity_r};

  always_comb begin
    capacity_nxt   = capacity_r;
    used_nxt       = used_r;
    line_start_nxt = line_start_r;
    failed_nxt     = failed_r;
    push_valid     = 1'b0;
    push_run.kind  = kind;
    push_run.data  = in_ch.data_byte;
    if (cfg_ch.valid) begin
      capacity_nxt = cfg_ch.message_capacity;
    end
    if (accept) begin
      if (in_ch.action == ACT_START) begin
        used_nxt       = in_ch.header_length;
        line_start_nxt = 1'b1;
        failed_nxt     = in_ch.header_length >= capacity_r;
        push_valid     = in_ch.header_length >= capacity_r;
        push_run.kind  = RUN_OVF;
      end else if (has_run) begin
        push_valid = 1'b1;
        if (fits) begin
          used_nxt       = sum[15:0];
          line_start_nxt = (kind != RUN_BYTE) && (kind != RUN_DOTDOT);
        end else begin
          failed_nxt    = 1'b1;
          push_run.kind = RUN_OVF;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r   <= CAPACITY_RESET;
      used_r       <= 16'd0;
      line_start_r <= 1'b1;
      failed_r     <= 1'b0;
    end else begin
      capacity_r   <= capacity_nxt;
      used_r       <= used_nxt;
      line_start_r <= line_start_nxt;
      failed_r     <= failed_nxt;
    end
  end

endmodule

// ----- rtl/sds_queue.sv -----
module sds_queue
  import sds_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  run_t push_run,
  output logic head_valid,
  input  logic pop,
  output run_t head_run
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  run_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_run   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/sds_back.sv -----
module sds_back
  import sds_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic head_valid,
  input  run_t head_run,
  output logic pop,
  sds_out_if.source out_ch
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_ovf_r;
  logic [2:0] pos_r, pos_nxt;
  logic       slot_free;
  logic       emit;
  logic       run_end;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign emit      = head_valid && slot_free;
  assign run_end   = pos_r == run_len(head_run.kind) - 3'd1;
  assign pop       = emit && run_end;

  always_comb begin
    out_valid_nxt = out_valid_r;
    pos_nxt       = pos_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      pos_nxt       = run_end ? 3'd0 : pos_r + 3'd1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= run_byte(head_run, pos_r);
      out_last_r <= run_end;
      out_ovf_r  <= head_run.kind == RUN_OVF;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;
  assign out_ch.overflow = out_ovf_r;

endmodule

// ----- rtl/smtp_body_dot_stuffer_top.sv -----
// Channel   Dir  Payload                                  Accepted when
// in_ch     in   action, data_byte, header_length         valid && ready
// out_ch    out  out_byte, last, overflow                 valid && ready
// cfg_ch    in   message_capacity                         valid && ready (always ready)
//
// One byte per cycle from the output register while out_ch is ready; a body byte
// gives 0 (CR), 1 or 2 bytes, an end item 3 or 5, a start 0 or 1 (overflow).
// The input is taken every cycle while the run queue (QUEUE_DEPTH runs) has room.
// An input item is registered into the run queue, then into the output register.
// Reset: synchronous, active low; capacity returns to 2048, queue empties.
// A stalled output holds its byte; the queue fills and then drops in_ch.ready.
module smtp_body_dot_stuffer_top
  import sds_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  sds_in_if.sink    in_ch,
  sds_cfg_if.sink   cfg_ch,
  sds_out_if.source out_ch
);

`include "smtp_body_dot_stuffer_top_macros.svh"

  logic push_valid;
  logic push_ready;
  run_t push_run;
  logic head_valid;
  logic pop;
  run_t head_run;

  sds_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_run   (push_run)
  );

  sds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_run   (push_run),
    .head_valid (head_valid),
    .pop        (pop),
    .head_run   (head_run)
  );

  sds_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_run   (head_run),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  `SDS_ASSERT_NOW(a_push_has_room, clk, rst_n, push_valid, push_ready, "run pushed into full queue")
  `SDS_ASSERT_NOW(a_ovf_single, clk, rst_n, out_ch.valid && out_ch.overflow, out_ch.last && (out_ch.out_byte == 8'h00), "overflow result not a lone zero item")
  `SDS_ASSERT_NEXT(a_pop_on_emit, clk, rst_n, pop, out_ch.valid, "run popped without an output item")

endmodule
